>>> src/utf8s_pkg.sv
package utf8s_pkg;

   // Default width of the per-string character counter
   localparam int INDEX_BITS_DEFAULT = 16;

   // Width of the index reported on the result channel
   localparam int INDEX_OUT_BITS = 16;
   localparam logic [INDEX_OUT_BITS-1:0] INDEX_OUT_MAX = '1;

   // Longest UTF-8 character and the number of bytes held while one is open
   localparam int CHAR_BYTES_MAX = 4;
   localparam int HELD_BYTES = CHAR_BYTES_MAX - 1;

   // Result queue depth; a power of two so the pointers wrap on their own
   localparam int RESULT_QUEUE_DEPTH = 4;

   // Result status codes
   localparam logic [1:0] STATUS_CHAR  = 2'd0;
   localparam logic [1:0] STATUS_TERM  = 2'd1;
   localparam logic [1:0] STATUS_ERROR = 2'd2;

   localparam logic [7:0] NUL_BYTE = 8'h00;

   // One result transaction
   typedef struct packed {
      logic [CHAR_BYTES_MAX-1:0][7:0] char_bytes;
      logic [2:0]                     char_length;
      logic [1:0]                     status;
      logic [INDEX_OUT_BITS-1:0]      char_index;
      logic                           run_end;
   } result_type;

   // Up to two results written into the queue in one cycle
   typedef struct packed {
      logic       push0;
      logic       push1;
      result_type first;
      result_type second;
   } push_type;

endpackage

>>> src/utf8s_decode.sv
module utf8s_decode #(
   parameter int INDEX_BITS = utf8s_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last_byte,
   input  logic                room,
   output utf8s_pkg::push_type push
);
   import utf8s_pkg::*;

   localparam logic [INDEX_BITS-1:0] COUNTER_MAX = '1;
   localparam logic [INDEX_BITS-1:0] INDEX_CLAMP = INDEX_BITS'(INDEX_OUT_MAX);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;

   // Segmentation state
   logic [7:0]            held_ff [HELD_BYTES];
   logic [7:0]            held_in [HELD_BYTES];
   logic [1:0]            held_count_ff, held_count_in;
   logic [2:0]            expected_ff, expected_in;
   logic [INDEX_BITS-1:0] counter_ff, counter_in;
   logic                  discarding_ff, discarding_in;

   logic                                process;
   logic                                trailing;
   logic [2:0]                          lead_len;
   logic [2:0]                          char_len;
   logic [CHAR_BYTES_MAX-1:0][7:0]      char_bytes;
   logic [INDEX_BITS-1:0]               counter_inc;
   logic [INDEX_OUT_BITS-1:0]           index_now;
   logic [INDEX_OUT_BITS-1:0]           index_next;
   logic                                term_only;
   logic                                error_hit;
   logic                                char_done;
   logic                                string_done;

   function automatic logic [INDEX_OUT_BITS-1:0] clamp_index(input logic [INDEX_BITS-1:0] v);
      clamp_index = (v > INDEX_CLAMP) ? INDEX_OUT_MAX : INDEX_OUT_BITS'(v);
   endfunction

   // Take a new byte whenever the register is empty or drains this cycle
   assign process   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   // Classify the byte
   assign trailing = (byte_ff[7:6] == 2'b10);

   always_comb begin
      priority if (byte_ff[7:5] == 3'b110) begin
         lead_len = 3'd2;
      end else if (byte_ff[7:4] == 4'b1110) begin
         lead_len = 3'd3;
      end else if (byte_ff[7:3] == 5'b11110) begin
         lead_len = 3'd4;
      end else begin
         lead_len = 3'd0;
      end
   end

   // Assemble the character from held bytes plus the current one
   always_comb begin
      char_bytes = '0;
      for (int i = 0; i < HELD_BYTES; i++) begin
         if (2'(i) < held_count_ff) begin
            char_bytes[i] = held_ff[i];
         end
      end
      char_bytes[held_count_ff] = byte_ff;
   end

   assign char_len    = {1'b0, held_count_ff} + 3'd1;
   assign counter_inc = (counter_ff == COUNTER_MAX) ? counter_ff : counter_ff + 1'b1;
   assign index_now   = clamp_index(counter_ff);
   assign index_next  = clamp_index(counter_inc);

   // Decide what this byte does
   always_comb begin
      held_in       = held_ff;
      held_count_in = held_count_ff;
      expected_in   = expected_ff;
      term_only     = 1'b0;
      error_hit     = 1'b0;
      char_done     = 1'b0;
      string_done   = 1'b0;
      if (process) begin
         if (discarding_ff) begin
            string_done = last_ff;
         end else if (held_count_ff == 2'd0) begin
            priority if (byte_ff == NUL_BYTE) begin
               term_only = 1'b1;
            end else if (!byte_ff[7]) begin
               char_done = 1'b1;
            end else if (lead_len == 3'd0 || last_ff) begin
               error_hit = 1'b1;
            end else begin
               held_in[0]    = byte_ff;
               held_count_in = 2'd1;
               expected_in   = lead_len;
            end
         end else begin
            priority if (!trailing) begin
               error_hit = 1'b1;
            end else if (char_len >= expected_ff) begin
               char_done = 1'b1;
            end else if (last_ff) begin
               error_hit = 1'b1;
            end else begin
               held_in[held_count_ff] = byte_ff;
               held_count_in          = held_count_ff + 2'd1;
            end
         end
      end
   end

   // Build results and the next state
   always_comb begin
      push          = '0;
      counter_in    = counter_ff;
      discarding_in = discarding_ff;
      if (term_only) begin
         push.push0              = 1'b1;
         push.first.char_length  = 3'd1;
         push.first.status       = STATUS_TERM;
         push.first.char_index   = index_now;
         push.first.run_end      = 1'b1;
         discarding_in           = !last_ff;
      end
      if (error_hit) begin
         push.push0              = 1'b1;
         push.first.status       = STATUS_ERROR;
         push.first.char_index   = index_now;
         push.first.run_end      = 1'b1;
         discarding_in           = !last_ff;
      end
      if (char_done) begin
         push.push0              = 1'b1;
         push.first.char_bytes   = char_bytes;
         push.first.char_length  = char_len;
         push.first.status       = STATUS_CHAR;
         push.first.char_index   = index_now;
         push.first.run_end      = !last_ff;
         counter_in              = counter_inc;
         if (last_ff) begin
            push.push1              = 1'b1;
            push.second.char_length = 3'd1;
            push.second.status      = STATUS_TERM;
            push.second.char_index  = index_next;
            push.second.run_end     = 1'b1;
         end
      end
      // Return to the reset state at the end of a string
      if (string_done || ((term_only || error_hit || char_done) && last_ff)) begin
         counter_in    = '0;
         discarding_in = 1'b0;
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         held_count_ff <= 2'd0;
         expected_ff   <= 3'd0;
         counter_ff    <= '0;
         discarding_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (term_only || error_hit || char_done || string_done) begin
            held_count_ff <= 2'd0;
            expected_ff   <= 3'd0;
         end else begin
            held_count_ff <= held_count_in;
            expected_ff   <= expected_in;
         end
         counter_ff    <= counter_in;
         discarding_ff <= discarding_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff <= req_data_byte;
         last_ff <= req_last_byte;
      end
      held_ff <= held_in;
   end

   // An open character always has bytes still to come
   assert property (@(posedge clock) disable iff (reset)
      (held_count_ff != 2'd0) |-> ({1'b0, held_count_ff} < expected_ff))
      else $error("held count not below expected length");

   // Dropping bytes never coexists with an open character
   assert property (@(posedge clock) disable iff (reset)
      discarding_ff |-> (held_count_ff == 2'd0))
      else $error("discarding with bytes held");

   // A second result is only a terminator after a character
   assert property (@(posedge clock) disable iff (reset)
      push.push1 |-> (push.push0 && push.first.status == STATUS_CHAR &&
                      push.second.status == STATUS_TERM))
      else $error("bad result pair");

endmodule

>>> src/utf8s_result_queue.sv
module utf8s_result_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  utf8s_pkg::push_type   push,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output utf8s_pkg::result_type head
);
   import utf8s_pkg::*;

   localparam int DEPTH    = RESULT_QUEUE_DEPTH;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   result_type            entries_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  pop;

   // Room for a full pair of results
   assign room      = (count_ff <= CNT_BITS'(DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign head      = entries_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.push0) + PTR_BITS'(push.push1);
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
      count_in  = count_ff + CNT_BITS'(push.push0) + CNT_BITS'(push.push1) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store incoming results
   always_ff @(posedge clock) begin
      if (push.push0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.push1) begin
         entries_ff[wr_ptr_ff + PTR_BITS'(1)] <= push.second;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("result queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      push.push0 |-> room)
      else $error("push without room");

   // Hold a stalled result steady
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(head)))
      else $error("stalled result changed");

endmodule

>>> src/utf8_char_segmenter.sv
// UTF-8 character segmenter. Feed a string one byte per transaction with
// req_last_byte set on its final byte; each complete character comes out as
// one result carrying its bytes, length and index within the string, a NUL at
// a character start or the end of the string on a character boundary gives a
// terminator, and malformed input gives one error result after which the rest
// of the string is dropped silently. The block accepts one byte per clock
// while the result queue has room: a byte is held in the input register and
// its results are written into a four-entry result queue that drives the
// rsp_ ports. A final byte that completes a character yields two results,
// which leave the queue one after the other; the result queue absorbs this,
// and the input stalls only while the queue holds more than two results.
module utf8_char_segmenter #(
   parameter int INDEX_BITS = utf8s_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [7:0]                                req_data_byte,
   input  logic                                      req_last_byte,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [7:0]                                rsp_char_byte0,
   output logic [7:0]                                rsp_char_byte1,
   output logic [7:0]                                rsp_char_byte2,
   output logic [7:0]                                rsp_char_byte3,
   output logic [2:0]                                rsp_char_length,
   output logic [1:0]                                rsp_status,
   output logic [utf8s_pkg::INDEX_OUT_BITS-1:0]      rsp_char_index,
   output logic                                      rsp_run_end
);
   import utf8s_pkg::*;

   push_type   push;
   logic       room;
   result_type head;

   utf8s_decode #(
      .INDEX_BITS (INDEX_BITS)
   ) u_decode (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .room          (room),
      .push          (push)
   );

   utf8s_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   // Unpack the head result onto the ports
   assign rsp_char_byte0  = head.char_bytes[0];
   assign rsp_char_byte1  = head.char_bytes[1];
   assign rsp_char_byte2  = head.char_bytes[2];
   assign rsp_char_byte3  = head.char_bytes[3];
   assign rsp_char_length = head.char_length;
   assign rsp_status      = head.status;
   assign rsp_char_index  = head.char_index;
   assign rsp_run_end     = head.run_end;

endmodule

>>> test/tb_utf8_char_segmenter.sv
module tb_utf8_char_segmenter;
   import utf8s_pkg::*;

   // One result transaction, field by field
   typedef struct packed {
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic [7:0]  byte3;
      logic [2:0]  length;
      logic [1:0]  status;
      logic [15:0] index;
      logic        run_end;
   } char_result_type;

   // One input transaction; typed rows carry their own expected results
   typedef struct packed {
      logic [7:0]      data;
      logic            last;
      logic            typed;
      logic [1:0]      n_typed;
      char_result_type first;
      char_result_type second;
   } byte_txn_type;

   localparam int RANDOM_ITEMS = 1020;
   localparam int HOLD_CYCLES  = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_char_byte0;
   logic [7:0]  rsp_char_byte1;
   logic [7:0]  rsp_char_byte2;
   logic [7:0]  rsp_char_byte3;
   logic [2:0]  rsp_char_length;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_char_index;
   logic        rsp_run_end;

   byte_txn_type    dir_table[$];
   byte_txn_type    string_bytes[$];
   byte_txn_type    cur_byte;
   char_result_type step_chars[$];
   char_result_type expected_chars[$];
   int              items_accepted = 0;
   int              total_items;
   int              mismatch_count = 0;
   int              hold_left = 0;
   bit              hold_done = 1'b0;

   // Segmenter state mirrored by the predictor
   logic [7:0]  seg_held[3];
   logic [2:0]  seg_expect_len;
   logic [1:0]  seg_held_cnt;
   logic [15:0] seg_char_cnt;
   logic        seg_discarding;

   utf8_char_segmenter u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_char_byte0  (rsp_char_byte0),
      .rsp_char_byte1  (rsp_char_byte1),
      .rsp_char_byte2  (rsp_char_byte2),
      .rsp_char_byte3  (rsp_char_byte3),
      .rsp_char_length (rsp_char_length),
      .rsp_status      (rsp_status),
      .rsp_char_index  (rsp_char_index),
      .rsp_run_end     (rsp_run_end)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Build a result whose only nonzero byte is the first
   function automatic char_result_type res(input logic [7:0] b0, input logic [2:0] len,
                                           input logic [1:0] st, input logic [15:0] idx,
                                           input logic run_end);
      char_result_type r;
      r = '0;
      r.byte0   = b0;
      r.length  = len;
      r.status  = st;
      r.index   = idx;
      r.run_end = run_end;
      return r;
   endfunction

   function automatic byte_txn_type plain_byte(input logic [7:0] data, input logic last);
      byte_txn_type t;
      t = '0;
      t.data = data;
      t.last = last;
      return t;
   endfunction

   function automatic byte_txn_type typed_byte(input logic [7:0] data, input logic last,
                                               input logic [1:0] n, input char_result_type r0,
                                               input char_result_type r1);
      byte_txn_type t;
      t = plain_byte(data, last);
      t.typed   = 1'b1;
      t.n_typed = n;
      t.first   = r0;
      t.second  = r1;
      return t;
   endfunction

   function automatic logic [7:0] lead_byte(input int len);
      case (len)
         1: return 8'($urandom_range(1, 127));
         2: return {3'b110, 5'($urandom)};
         3: return {4'b1110, 4'($urandom)};
         default: return {5'b11110, 3'($urandom)};
      endcase
   endfunction

   // Return the segmenter to the start of a string
   task automatic clear_string();
      seg_char_cnt   = '0;
      seg_held_cnt   = '0;
      seg_expect_len = '0;
      seg_discarding = 1'b0;
   endtask

   task automatic add_char(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                           input logic [7:0] b3, input logic [2:0] len, input logic [1:0] st,
                           input logic run_end);
      char_result_type r;
      r.byte0   = b0;
      r.byte1   = b1;
      r.byte2   = b2;
      r.byte3   = b3;
      r.length  = len;
      r.status  = st;
      r.index   = seg_char_cnt;
      r.run_end = run_end;
      step_chars.push_back(r);
   endtask

   task automatic flag_error(input logic last);
      add_char(8'h00, 8'h00, 8'h00, 8'h00, 3'd0, STATUS_ERROR, 1'b1);
      seg_held_cnt   = '0;
      seg_expect_len = '0;
      if (last) clear_string();
      else seg_discarding = 1'b1;
   endtask

   // Emit a whole character, plus the terminator when the string ends on it
   task automatic finish_char(input logic [7:0] cb[4], input logic [2:0] len,
                              input logic last);
      add_char(cb[0], cb[1], cb[2], cb[3], len, STATUS_CHAR, !last);
      if (seg_char_cnt != 16'hFFFF) seg_char_cnt = seg_char_cnt + 16'd1;
      seg_held_cnt   = '0;
      seg_expect_len = '0;
      if (last) begin
         add_char(NUL_BYTE, 8'h00, 8'h00, 8'h00, 3'd1, STATUS_TERM, 1'b1);
         clear_string();
      end
   endtask

   // Work out the results that one byte causes
   task automatic predict_segment(input logic [7:0] b, input logic last);
      logic [7:0] cb[4];
      logic [2:0] lead_len;
      int         hc;
      step_chars.delete();
      for (int i = 0; i < 4; i++) cb[i] = 8'h00;
      hc = seg_held_cnt;
      if (seg_discarding) begin
         if (last) clear_string();
      end else if (hc == 0) begin
         if (b == NUL_BYTE) begin
            add_char(NUL_BYTE, 8'h00, 8'h00, 8'h00, 3'd1, STATUS_TERM, 1'b1);
            if (last) clear_string();
            else seg_discarding = 1'b1;
         end else if (b < 8'h80) begin
            cb[0] = b;
            finish_char(cb, 3'd1, last);
         end else begin
            if ((b & 8'hE0) == 8'hC0) lead_len = 3'd2;
            else if ((b & 8'hF0) == 8'hE0) lead_len = 3'd3;
            else if ((b & 8'hF8) == 8'hF0) lead_len = 3'd4;
            else lead_len = 3'd0;
            if (lead_len == 3'd0 || last) begin
               flag_error(last);
            end else begin
               seg_held[0]    = b;
               seg_held_cnt   = 2'd1;
               seg_expect_len = lead_len;
            end
         end
      end else begin
         if ((b & 8'hC0) != 8'h80) begin
            flag_error(last);
         end else if (hc + 1 >= seg_expect_len) begin
            for (int i = 0; i < hc; i++) cb[i] = seg_held[i];
            cb[hc] = b;
            finish_char(cb, 3'(hc + 1), last);
         end else if (last) begin
            flag_error(last);
         end else begin
            seg_held[hc] = b;
            seg_held_cnt = 2'(hc + 1);
         end
      end
   endtask

   // Queue one random string, mostly well formed
   task automatic gen_string();
      logic [7:0] s[$];
      int         n_chars;
      int         kind;
      int         len;
      n_chars = $urandom_range(1, 12);
      for (int c = 0; c < n_chars; c++) begin
         kind = $urandom_range(0, 99);
         len  = $urandom_range(1, 4);
         if (kind < 3) begin
            s.push_back(NUL_BYTE);
         end else if (kind < 88) begin
            s.push_back(lead_byte(len));
            for (int k = 1; k < len; k++) s.push_back({2'b10, 6'($urandom)});
         end else if (kind < 94) begin
            s.push_back(8'($urandom));
         end else begin
            // cut a character short
            len = $urandom_range(2, 4);
            s.push_back(lead_byte(len));
            repeat ($urandom_range(0, len - 2)) s.push_back({2'b10, 6'($urandom)});
         end
      end
      // end the string mid-character now and then
      if (s.size() > 2 && $urandom_range(0, 9) == 0) void'(s.pop_back());
      foreach (s[i]) string_bytes.push_back(plain_byte(s[i], i == s.size() - 1));
   endtask

   // Drive input transactions and predict on each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         for (int i = 0; i < 3; i++) seg_held[i] = 8'h00;
         clear_string();
      end else begin
         if (req_valid && !req_stall) begin
            predict_segment(cur_byte.data, cur_byte.last);
            if (cur_byte.typed) begin
               if (cur_byte.n_typed > 0) expected_chars.push_back(cur_byte.first);
               if (cur_byte.n_typed > 1) expected_chars.push_back(cur_byte.second);
            end else begin
               foreach (step_chars[i]) expected_chars.push_back(step_chars[i]);
            end
            items_accepted <= items_accepted + 1;
         end
         if (!req_valid || !req_stall) begin
            if (string_bytes.size() != 0 &&
                ((items_accepted >= 500 && items_accepted < 800) ||
                 $urandom_range(0, 99) >= 7)) begin
               cur_byte = string_bytes.pop_front();
               req_valid     <= 1'b1;
               req_data_byte <= cur_byte.data;
               req_last_byte <= cur_byte.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(input string name, input logic [15:0] exp_val,
                                       input logic [15:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
         mismatch_count++;
      end
   endfunction

   // Take result transactions and compare against the oldest expectation
   always @(posedge clock) begin
      char_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $error("result with no expectation: status %0h index %0h",
                      rsp_status, rsp_char_index);
               mismatch_count++;
            end else begin
               want = expected_chars.pop_front();
               check_field("char_byte0", want.byte0, rsp_char_byte0);
               check_field("char_byte1", want.byte1, rsp_char_byte1);
               check_field("char_byte2", want.byte2, rsp_char_byte2);
               check_field("char_byte3", want.byte3, rsp_char_byte3);
               check_field("char_length", want.length, rsp_char_length);
               check_field("status", want.status, rsp_status);
               check_field("char_index", want.index, rsp_char_index);
               check_field("run_end", want.run_end, rsp_run_end);
            end
         end
         // hold off once for a long stretch so the block backs up
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (!hold_done && items_accepted >= 60) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !(items_accepted >= 500 && items_accepted < 800) &&
                         ($urandom_range(0, 99) < 7);
         end
      end
   end

   initial begin
      // ASCII, end of string on a character, NUL handling
      dir_table.push_back(typed_byte(8'h41, 1'b0, 2'd1,
                          res(8'h41, 3'd1, STATUS_CHAR, 16'd0, 1'b1), '0));
      dir_table.push_back(typed_byte(8'h7F, 1'b0, 2'd1,
                          res(8'h7F, 3'd1, STATUS_CHAR, 16'd1, 1'b1), '0));
      dir_table.push_back(typed_byte(8'h01, 1'b1, 2'd2,
                          res(8'h01, 3'd1, STATUS_CHAR, 16'd2, 1'b0),
                          res(NUL_BYTE, 3'd1, STATUS_TERM, 16'd3, 1'b1)));
      dir_table.push_back(typed_byte(NUL_BYTE, 1'b1, 2'd1,
                          res(NUL_BYTE, 3'd1, STATUS_TERM, 16'd0, 1'b1), '0));
      dir_table.push_back(typed_byte(NUL_BYTE, 1'b0, 2'd1,
                          res(NUL_BYTE, 3'd1, STATUS_TERM, 16'd0, 1'b1), '0));
      dir_table.push_back(plain_byte(8'hFF, 1'b0));
      dir_table.push_back(plain_byte(8'h80, 1'b1));
      // two, three and four byte characters, the last one ending the string
      dir_table.push_back(plain_byte(8'hC2, 1'b0));
      dir_table.push_back(plain_byte(8'hA9, 1'b0));
      dir_table.push_back(plain_byte(8'hE2, 1'b0));
      dir_table.push_back(plain_byte(8'h82, 1'b0));
      dir_table.push_back(plain_byte(8'hAC, 1'b0));
      dir_table.push_back(plain_byte(8'hF0, 1'b0));
      dir_table.push_back(plain_byte(8'h9F, 1'b0));
      dir_table.push_back(plain_byte(8'h98, 1'b0));
      dir_table.push_back(plain_byte(8'h80, 1'b1));
      // bad lead byte, then dropped bytes up to the string end
      dir_table.push_back(typed_byte(8'h80, 1'b0, 2'd1,
                          res(8'h00, 3'd0, STATUS_ERROR, 16'd0, 1'b1), '0));
      dir_table.push_back(plain_byte(8'h55, 1'b1));
      // NUL inside a character
      dir_table.push_back(plain_byte(8'hF4, 1'b0));
      dir_table.push_back(plain_byte(8'h8F, 1'b0));
      dir_table.push_back(plain_byte(NUL_BYTE, 1'b0));
      dir_table.push_back(plain_byte(8'h12, 1'b1));
      // string ends inside a character
      dir_table.push_back(plain_byte(8'hE1, 1'b0));
      dir_table.push_back(plain_byte(8'hBF, 1'b1));
      dir_table.push_back(typed_byte(8'hFF, 1'b1, 2'd1,
                          res(8'h00, 3'd0, STATUS_ERROR, 16'd0, 1'b1), '0));
      foreach (dir_table[i]) string_bytes.push_back(dir_table[i]);

      while (string_bytes.size() < dir_table.size() + RANDOM_ITEMS) gen_string();
      total_items = string_bytes.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted != total_items) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   // Bound the run
   initial begin
      #20000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
